// ===== sv/tfn_pkg.sv =====
// shared constants for the triangle face normal pipeline
package tfn_pkg;

  // width of one result component, signed q1.15
  localparam int unsigned NormWidth  = 16;
  // magnitude bits resolved by the cell chain
  localparam int unsigned QBits      = 15;
  // one cell per magnitude bit
  localparam int unsigned NumCells   = QBits;
  // register stages ahead of the cell chain
  localparam int unsigned FrontDepth = 9;
  // scale of the squared test, 2^32 = (2 * 32768)^2
  localparam int unsigned ScaleShift = 32;

endpackage

// ===== sv/tfn_front.sv =====
// front pipeline: edges, cross product, squared length and first remainder
module tfn_front
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned EW = 4 * COORD_WIDTH + 40,
  parameter int unsigned SW = 4 * COORD_WIDTH + 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [FrontDepth-1:0]         en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i [9],
  output logic [FrontDepth-1:0]         valid_o,
  output logic signed [EW-1:0]          e_o [3],
  output logic signed [EW-1:0]          r_o [3],
  output logic [SW-1:0]                 s_o,
  output logic                          neg_o [3],
  output logic                          degen_o
);

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * COORD_WIDTH + 2;
  localparam int unsigned MW  = 2 * COORD_WIDTH + 1;
  localparam int unsigned H   = (MW + 1) / 2;
  localparam int unsigned HiW = MW - H;
  localparam int unsigned SQW = 2 * MW;

  logic [FrontDepth-1:0] valid_q;

  logic signed [COORD_WIDTH-1:0] c_q [9];
  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [PW-1:0] p_q [6];
  logic signed [PW-1:0] n_q [3];
  logic [MW-1:0]        mag_q [3];
  logic [2*HiW-1:0]     hh_q [3];
  logic [MW-1:0]        hl_q [3];
  logic [2*H-1:0]       ll_q [3];
  logic [SQW-1:0]       sq_q [3];
  logic [SQW-1:0]       sq7_q [3];
  logic [SW-1:0]        s7_q;
  logic [SW-1:0]        s8_q;
  logic                 degen7_q;
  logic                 degen8_q;
  logic signed [EW-1:0] e_q [3];
  logic signed [EW-1:0] r_q [3];
  logic                 neg4_q [3];
  logic                 neg5_q [3];
  logic                 neg6_q [3];
  logic                 neg7_q [3];
  logic                 neg8_q [3];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int k = 1; k < FrontDepth; k++) begin
        if (en_i[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 0: input capture
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c_q <= coord_i;
    end
  end

  // stage 1: edges u = b - a, v = c - a
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < 3; j++) begin
        u_q[j] <= DW'(c_q[3+j]) - DW'(c_q[j]);
        v_q[j] <= DW'(c_q[6+j]) - DW'(c_q[j]);
      end
    end
  end

  // stage 2: the six cross product terms
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
      p_q[1] <= PW'(v_q[1]) * PW'(u_q[2]);
      p_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
      p_q[3] <= PW'(v_q[2]) * PW'(u_q[0]);
      p_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
      p_q[5] <= PW'(v_q[0]) * PW'(u_q[1]);
    end
  end

  // stage 3: cross product components
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int j = 0; j < 3; j++) begin
        n_q[j] <= p_q[2*j] - p_q[2*j+1];
      end
    end
  end

  // stage 4: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int j = 0; j < 3; j++) begin
        neg4_q[j] <= n_q[j][PW-1];
        mag_q[j]  <= n_q[j][PW-1] ? MW'(-n_q[j]) : MW'(n_q[j]);
      end
    end
  end

  // stage 5: partial products of the square, split in halves
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      for (int j = 0; j < 3; j++) begin
        neg5_q[j] <= neg4_q[j];
        hh_q[j]   <= (2*HiW)'(mag_q[j][MW-1:H]) * (2*HiW)'(mag_q[j][MW-1:H]);
        hl_q[j]   <= MW'(mag_q[j][MW-1:H]) * MW'(mag_q[j][H-1:0]);
        ll_q[j]   <= (2*H)'(mag_q[j][H-1:0]) * (2*H)'(mag_q[j][H-1:0]);
      end
    end
  end

  // stage 6: squared components
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      for (int j = 0; j < 3; j++) begin
        neg6_q[j] <= neg5_q[j];
        sq_q[j]   <= (SQW'(hh_q[j]) << (2 * H)) + (SQW'(hl_q[j]) << (H + 1))
                     + SQW'(ll_q[j]);
      end
    end
  end

  // stage 7: squared length and zero check
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      neg7_q   <= neg6_q;
      sq7_q    <= sq_q;
      s7_q     <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      degen7_q <= ~|(sq_q[0] | sq_q[1] | sq_q[2]);
    end
  end

  // stage 8: remainder 2^32 n^2 - s and running term -s for q = 0
  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      neg8_q   <= neg7_q;
      s8_q     <= s7_q;
      degen8_q <= degen7_q;
      for (int j = 0; j < 3; j++) begin
        e_q[j] <= (EW'(sq7_q[j]) << ScaleShift) - EW'(s7_q);
        r_q[j] <= -EW'(s7_q);
      end
    end
  end

  assign valid_o = valid_q;
  assign e_o     = e_q;
  assign r_o     = r_q;
  assign s_o     = s8_q;
  assign neg_o   = neg8_q;
  assign degen_o = degen8_q;

endmodule

// ===== sv/tfn_cell.sv =====
// one cell of the chain: settles one magnitude bit of all three components
module tfn_cell
  import tfn_pkg::*;
#(
  parameter int unsigned BIT = 14,
  parameter int unsigned EW  = 104,
  parameter int unsigned SW  = 68
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [EW-1:0] e_i [3],
  input  logic signed [EW-1:0] r_i [3],
  input  logic [SW-1:0]        s_i,
  input  logic [QBits-1:0]     q_i [3],
  input  logic                 neg_i [3],
  input  logic                 degen_i,
  output logic                 valid_o,
  output logic signed [EW-1:0] e_o [3],
  output logic signed [EW-1:0] r_o [3],
  output logic [SW-1:0]        s_o,
  output logic [QBits-1:0]     q_o [3],
  output logic                 neg_o [3],
  output logic                 degen_o
);

  logic                 valid_q;
  logic signed [EW-1:0] e_q [3];
  logic signed [EW-1:0] r_q [3];
  logic [SW-1:0]        s_q;
  logic [QBits-1:0]     q_q [3];
  logic                 neg_q [3];
  logic                 degen_q;

  logic signed [EW-1:0] sx;
  logic signed [EW-1:0] t [3];
  logic                 take [3];

  // trial remainder with this bit set: e - 2^(b+2) r - 2^(2b+2) s
  always_comb begin
    sx = $signed(EW'(s_i));
    for (int j = 0; j < 3; j++) begin
      t[j]    = e_i[j] - (r_i[j] <<< (BIT + 2)) - (sx <<< (2 * BIT + 2));
      take[j] = ~t[j][EW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // keep the trial when it stays non-negative
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= s_i;
      neg_q   <= neg_i;
      degen_q <= degen_i;
      for (int j = 0; j < 3; j++) begin
        e_q[j] <= take[j] ? t[j] : e_i[j];
        r_q[j] <= take[j] ? r_i[j] + (sx <<< (BIT + 1)) : r_i[j];
        q_q[j] <= q_i[j] | (QBits'(take[j]) << BIT);
      end
    end
  end

  assign valid_o = valid_q;
  assign e_o     = e_q;
  assign r_o     = r_q;
  assign s_o     = s_q;
  assign q_o     = q_q;
  assign neg_o   = neg_q;
  assign degen_o = degen_q;

endmodule

// ===== sv/triangle_face_normal.sv =====
// top level: unit face normal of a triangle, one triangle per clock while the output is not stalled
//
// Takes vertices a, b, c and returns the cross product (b-a) x (c-a) scaled
// to unit length in signed q1.15, rounded to nearest and limited to 32767;
// a zero cross product gives a zero normal with degenerate set. While the
// output is not stalled, a new triangle is taken and one normal comes out
// every cycle. Nine front stages (edges, products, squares, squared length)
// feed fifteen cells that each settle one bit of all three magnitudes by an
// exact integer compare, then the output register. Stages that hold no
// transaction close up under a stall, so the input stays ready while any
// stage is empty.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_coord_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [NormWidth-1:0]  nx_o,
  output logic signed [NormWidth-1:0]  ny_o,
  output logic signed [NormWidth-1:0]  nz_o,
  output logic                         degenerate_o
);

  localparam int unsigned EW = 4 * COORD_WIDTH + 40;
  localparam int unsigned SW = 4 * COORD_WIDTH + 4;
  localparam int unsigned NS = FrontDepth + NumCells + 1;

  logic [NS-1:0] st_v;
  logic [NS-1:0] st_en;

  logic signed [COORD_WIDTH-1:0] coord [9];

  // chain links: link 0 is the front output, link k the output of cell k-1
  logic                 lk_v     [NumCells+1];
  logic signed [EW-1:0] lk_e     [NumCells+1][3];
  logic signed [EW-1:0] lk_r     [NumCells+1][3];
  logic [SW-1:0]        lk_s     [NumCells+1];
  logic [QBits-1:0]     lk_q     [NumCells+1][3];
  logic                 lk_neg   [NumCells+1][3];
  logic                 lk_degen [NumCells+1];

  logic                        out_v_q;
  logic signed [NormWidth-1:0] n_q [3];
  logic                        degen_q;
  logic signed [NormWidth-1:0] n_d [3];

  assign coord = '{ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i};

  // a stage loads when it is empty or its content moves on
  always_comb begin
    st_en[NS-1] = ~st_v[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      st_en[k] = ~st_v[k] | st_en[k+1];
    end
  end

  assign in_ready_o = st_en[0];

  tfn_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .EW         (EW),
    .SW         (SW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (st_en[FrontDepth-1:0]),
    .valid_i(in_valid_i),
    .coord_i(coord),
    .valid_o(st_v[FrontDepth-1:0]),
    .e_o    (lk_e[0]),
    .r_o    (lk_r[0]),
    .s_o    (lk_s[0]),
    .neg_o  (lk_neg[0]),
    .degen_o(lk_degen[0])
  );

  assign lk_v[0] = st_v[FrontDepth-1];
  assign lk_q[0] = '{default: '0};

  // bit-serial magnitude chain, most significant bit first
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tfn_cell #(
      .BIT(QBits - 1 - i),
      .EW (EW),
      .SW (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (st_en[FrontDepth+i]),
      .valid_i(lk_v[i]),
      .e_i    (lk_e[i]),
      .r_i    (lk_r[i]),
      .s_i    (lk_s[i]),
      .q_i    (lk_q[i]),
      .neg_i  (lk_neg[i]),
      .degen_i(lk_degen[i]),
      .valid_o(lk_v[i+1]),
      .e_o    (lk_e[i+1]),
      .r_o    (lk_r[i+1]),
      .s_o    (lk_s[i+1]),
      .q_o    (lk_q[i+1]),
      .neg_o  (lk_neg[i+1]),
      .degen_o(lk_degen[i+1])
    );
    assign st_v[FrontDepth+i] = lk_v[i+1];
  end

  assign st_v[NS-1] = out_v_q;

  // apply sign, zero the degenerate case
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (lk_degen[NumCells]) begin
        n_d[j] = '0;
      end else if (lk_neg[NumCells][j]) begin
        n_d[j] = -$signed(NormWidth'(lk_q[NumCells][j]));
      end else begin
        n_d[j] = $signed(NormWidth'(lk_q[NumCells][j]));
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (st_en[NS-1]) begin
      out_v_q <= lk_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_en[NS-1]) begin
      n_q     <= n_d;
      degen_q <= lk_degen[NumCells];
    end
  end

  assign out_valid_o  = out_v_q;
  assign nx_o         = n_q[0];
  assign ny_o         = n_q[1];
  assign nz_o         = n_q[2];
  assign degenerate_o = degen_q;

endmodule

// ===== sv/tfn_checker.sv =====
// port checker for the face normal block, bound to the top level
module tfn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] nx_o,
  input logic signed [15:0] ny_o,
  input logic signed [15:0] nz_o,
  input logic               degenerate_o
);

  // a waiting result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  // a waiting result keeps its normal components
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(nx_o) && $stable(ny_o) && $stable(nz_o))
    else $error("result changed while stalled");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> nx_o == 16'sd0 && ny_o == 16'sd0 && nz_o == 16'sd0)
    else $error("degenerate result with nonzero normal");

  // components stay inside the saturated range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nx_o != 16'sh8000 && ny_o != 16'sh8000 && nz_o != 16'sh8000)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .nx_o        (nx_o),
  .ny_o        (ny_o),
  .nz_o        (nz_o),
  .degenerate_o(degenerate_o)
);

// ===== test/triangle_face_normal_test.sv =====
// self-checking testbench for the triangle face normal pipeline
`timescale 1ns / 1ps

module triangle_face_normal_test;
  import tfn_pkg::*;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned NumRandom  = 1900;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned HoldCycles = 300;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormWidth-1:0] norm_t;

  typedef struct {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    logic  degenerate;
  } normal_t;

  typedef struct {
    coord_t  v[9];
    logic    typed;
    normal_t want;
  } vector_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i;
  logic   out_valid_o;
  logic   out_ready_i;
  norm_t  nx_o, ny_o, nz_o;
  logic   degenerate_o;

  normal_t     pending_normals[$];
  vector_row_t directed_rows[$];
  int unsigned error_count;
  int unsigned normals_seen;
  int unsigned idle_cycles;
  logic        hold_done;

  triangle_face_normal #(.COORD_WIDTH(CoordW)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ax_i         (ax_i),
    .ay_i         (ay_i),
    .az_i         (az_i),
    .bx_i         (bx_i),
    .by_coord_i   (by_coord_i),
    .bz_i         (bz_i),
    .cx_i         (cx_i),
    .cy_i         (cy_i),
    .cz_i         (cz_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .nx_o         (nx_o),
    .ny_o         (ny_o),
    .nz_o         (nz_o),
    .degenerate_o (degenerate_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // one signed q1.15 component, magnitude bit by bit: largest q with (2q-1)^2 * len2 <= 2^32 * n^2
  function automatic norm_t unit_part(longint comp, logic [127:0] len2);
    logic [127:0] mag;
    logic [127:0] lim;
    logic [127:0] k;
    logic [15:0]  q;
    logic [15:0]  c;
    mag = (comp < 0) ? -comp : comp;
    lim = (mag * mag) << ScaleShift;
    q = '0;
    for (int b = QBits - 1; b >= 0; b--) begin
      c = q | (16'd1 << b);
      k = 2 * c - 1;
      if (k * k * len2 <= lim) q = c;
    end
    return (comp < 0) ? -q : q;
  endfunction

  // exact cross product of the edges b - a and c - a, normalized
  function automatic normal_t face_normal(coord_t v[9]);
    longint       ux, uy, uz, wx, wy, wz, cx, cy, cz;
    logic [127:0] len2;
    logic [127:0] mx, my, mz;
    normal_t      r;
    ux = longint'(v[3]) - longint'(v[0]);
    uy = longint'(v[4]) - longint'(v[1]);
    uz = longint'(v[5]) - longint'(v[2]);
    wx = longint'(v[6]) - longint'(v[0]);
    wy = longint'(v[7]) - longint'(v[1]);
    wz = longint'(v[8]) - longint'(v[2]);
    cx = uy * wz - wy * uz;
    cy = uz * wx - wz * ux;
    cz = ux * wy - wx * uy;
    mx = (cx < 0) ? -cx : cx;
    my = (cy < 0) ? -cy : cy;
    mz = (cz < 0) ? -cz : cz;
    len2 = mx * mx + my * my + mz * mz;
    if (len2 == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1};
    end else begin
      r.nx = unit_part(cx, len2);
      r.ny = unit_part(cy, len2);
      r.nz = unit_part(cz, len2);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // present one triangle and hold it until the transaction completes
  task automatic send_triangle(vector_row_t row);
    in_valid_i <= 1'b1;
    ax_i <= row.v[0]; ay_i <= row.v[1]; az_i <= row.v[2];
    bx_i <= row.v[3]; by_coord_i <= row.v[4]; bz_i <= row.v[5];
    cx_i <= row.v[6]; cy_i <= row.v[7]; cz_i <= row.v[8];
    do @(posedge clk_i); while (!in_ready_o);
    pending_normals.push_back(row.typed ? row.want : face_normal(row.v));
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic add_row(coord_t a0, coord_t a1, coord_t a2, coord_t b0, coord_t b1,
                         coord_t b2, coord_t c0, coord_t c1, coord_t c2, logic typed,
                         norm_t ex, norm_t ey, norm_t ez, logic edeg);
    vector_row_t row;
    row.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    row.typed = typed;
    row.want = '{nx: ex, ny: ey, nz: ez, degenerate: edeg};
    directed_rows.push_back(row);
  endtask

  // random triangle: full range, small, or deliberately collinear
  function automatic vector_row_t random_row();
    vector_row_t row;
    int unsigned kind;
    int          k;
    kind = $urandom_range(99);
    row.typed = 1'b0;
    row.want = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b0};
    for (int i = 0; i < 9; i++) begin
      if (kind < 60) row.v[i] = coord_t'($urandom);
      else row.v[i] = coord_t'($urandom_range(32) - 16);
    end
    if (kind >= 90) begin
      k = $urandom_range(3) - 1;
      for (int i = 0; i < 3; i++)
        row.v[6 + i] = row.v[i] + coord_t'(k) * (row.v[3 + i] - row.v[i]);
    end else if (kind >= 85) begin
      for (int i = 0; i < 3; i++) row.v[3 + i] = row.v[i];
    end
    return row;
  endfunction

  // stimulus
  initial begin
    vector_row_t row;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i, cx_i, cy_i, cz_i} = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // degenerate: all points equal, collinear, extreme equal points
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 0, 0, 0, 1);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
            1, 0, 0, 0, 1);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
            1, 0, 0, 0, 1);
    // axis normals, both orientations, saturated at one
    add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 32767, 0);
    add_row(0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 0, 0, -32767, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 1, 1, 32767, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 0, 1, 0, 1, -32767, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 32767, 0, 0);
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 0, -32767, 0, 0);
    // full-span edges
    add_row(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
            1, 0, 0, 32767, 0);
    add_row(32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767, -32768,
            1, 0, -32767, 0, 0);
    // diagonal and odd directions, an axis case and a repeated point
    add_row(0, 0, 0, 1, -1, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 3, 0, 0, 0, 4, 5, 0, 0, 0, 0, 0);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768,
            0, 0, 0, 0, 0);
    add_row(32767, -32768, 0, -32768, 0, 32767, 0, 32767, -32768, 0, 0, 0, 0, 0);
    add_row(1, 2, 3, 1, 2, 4, 2, 2, 3, 0, 0, 0, 0, 0);
    add_row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      send_triangle(directed_rows[i]);
      pause_sender(idle_gap());
    end

    for (int n = 0; n < NumRandom; n++) begin
      // once, let the pipeline empty completely before going on
      if (n == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        while (pending_normals.size() != 0) @(negedge clk_i);
      end
      row = random_row();
      send_triangle(row);
      if ($urandom_range(3) == 0 || n < 200) pause_sender(0);
      else pause_sender(idle_gap());
    end
    in_valid_i <= 1'b0;

    while (pending_normals.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // receiver ready, with one long hold-off while the sender keeps going
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && normals_seen >= 300) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (normals_seen < 100 || normals_seen > 1700) gap = 0;
      else gap = idle_gap();
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      normals_seen <= normals_seen + 1;
      if (pending_normals.size() == 0) begin
        error_count++;
        $display("%0t: unexpected normal %0d %0d %0d deg %0b", $time, nx_o, ny_o, nz_o,
                 degenerate_o);
      end else begin
        want = pending_normals.pop_front();
        if (nx_o !== want.nx || ny_o !== want.ny || nz_o !== want.nz ||
            degenerate_o !== want.degenerate) begin
          error_count++;
          $display("%0t: expected %0d %0d %0d deg %0b, actual %0d %0d %0d deg %0b", $time,
                   want.nx, want.ny, want.nz, want.degenerate,
                   nx_o, ny_o, nz_o, degenerate_o);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    error_count = 0;
    normals_seen = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/tfn_pkg.sv
sv/tfn_front.sv
sv/tfn_cell.sv
sv/triangle_face_normal.sv
sv/tfn_checker.sv
test/triangle_face_normal_test.sv
